@@ hdl/vps_pkg.sv @@
// Shared constants and types of the volume priority stack.
`default_nettype none
package vps_pkg;

  // List depth and derived widths
  localparam int MAX_VOLUMES = 8;
  localparam int CNT_W       = $clog2(MAX_VOLUMES + 1);
  localparam int IDX_W       = (MAX_VOLUMES > 1) ? $clog2(MAX_VOLUMES) : 1;
  localparam int ID_W        = 8;
  localparam int PRIO_W      = 16;
  localparam int LIST_W      = 4;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VOLUMES);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_VALID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ID    = 1'b1;

  // Item kinds
  localparam logic KIND_SCATTER = 1'b0;
  localparam logic KIND_HIT     = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic                     kind;
    logic                     volume_scatter;
    logic                     transmit;
    logic                     into_object;
    logic                     null_material;
    logic                     interior_valid;
    logic [ID_W-1:0]          interior_id;
    logic signed [PRIO_W-1:0] interior_priority;
    logic                     exterior_valid;
    logic [ID_W-1:0]          exterior_id;
  } item_t;

  typedef struct packed {
    logic            default_valid;
    logic [ID_W-1:0] default_id;
  } cfg_t;

  typedef struct packed {
    logic              continue_trace;
    logic              hit_interior_valid;
    logic [ID_W-1:0]   hit_interior_id;
    logic              hit_exterior_valid;
    logic [ID_W-1:0]   hit_exterior_id;
    logic              current_valid;
    logic [ID_W-1:0]   current_id;
    logic              scattered_start;
    logic [LIST_W-1:0] list_count;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage
`default_nettype wire

@@ hdl/vps_ram.sv @@
// Generic simple dual-port RAM with one registered read port.
`default_nettype none
module vps_ram #(
  parameter int  DEPTH  = 8,
  parameter int  WIDTH  = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/vps_core.sv @@
// Sequencer of the volume priority stack: push, scan with compaction, result.
`default_nettype none
module vps_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  vps_pkg::item_t    item,
  input  vps_pkg::cfg_t     cfg,
  output vps_pkg::ram_req_t ram_req,
  input  vps_pkg::entry_t   ram_rdata,
  output logic              res_valid,
  input  logic              res_ready,
  output vps_pkg::result_t  res
);
  import vps_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_DONE} state_t;

  state_t                   state_r, state_nxt;
  item_t                    item_r, item_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     cur_present_r, cur_present_nxt;
  logic [ID_W-1:0]          cur_ident_r, cur_ident_nxt;
  logic signed [PRIO_W-1:0] cur_prio_r, cur_prio_nxt;
  logic                     scatter_r, scatter_nxt;
  logic [CNT_W-1:0]         rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]         wr_idx_r, wr_idx_nxt;
  logic                     pend_r, pend_nxt;
  logic                     found_r, found_nxt;
  logic                     bp_r, bp_nxt;
  logic [ID_W-1:0]          bid_r, bid_nxt;
  logic signed [PRIO_W-1:0] best_r, best_nxt;

  logic            is_remove;
  logic            sim_present;
  logic [ID_W-1:0] sim_id;

  assign is_remove = (item_r.kind == KIND_SCATTER);
  assign in_stall  = (state_r != S_IDLE);

  // Sequence the item through execute, scan and result
  always_comb begin
    state_nxt       = state_r;
    item_nxt        = item_r;
    count_nxt       = count_r;
    cur_present_nxt = cur_present_r;
    cur_ident_nxt   = cur_ident_r;
    cur_prio_nxt    = cur_prio_r;
    scatter_nxt     = scatter_r;
    rd_idx_nxt      = rd_idx_r;
    wr_idx_nxt      = wr_idx_r;
    pend_nxt        = pend_r;
    found_nxt       = found_r;
    bp_nxt          = bp_r;
    bid_nxt         = bid_r;
    best_nxt        = best_r;
    ram_req.we      = 1'b0;
    ram_req.waddr   = wr_idx_r[IDX_W-1:0];
    ram_req.wdata   = ram_rdata;
    ram_req.raddr   = rd_idx_r[IDX_W-1:0];
    res_valid       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = item;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt  = S_DONE;
        rd_idx_nxt = '0;
        wr_idx_nxt = '0;
        pend_nxt   = 1'b0;
        found_nxt  = 1'b0;
        bp_nxt     = 1'b0;
        if (item_r.kind == KIND_SCATTER) begin
          if (item_r.volume_scatter) begin
            scatter_nxt = 1'b1;
          end else begin
            scatter_nxt = 1'b0;
            if (item_r.transmit && item_r.interior_valid) begin
              if (item_r.into_object) begin
                // Push at the tail unless the list is full
                if (count_r != MAX_CNT) begin
                  ram_req.we       = 1'b1;
                  ram_req.waddr    = count_r[IDX_W-1:0];
                  ram_req.wdata.id   = item_r.interior_id;
                  ram_req.wdata.prio = item_r.interior_priority;
                  count_nxt        = count_r + 1'b1;
                  if (!cur_present_r ||
                      $signed(item_r.interior_priority) >= cur_prio_r) begin
                    cur_present_nxt = 1'b1;
                    cur_ident_nxt   = item_r.interior_id;
                    cur_prio_nxt    = item_r.interior_priority;
                  end
                end
              end else if (count_r != '0) begin
                state_nxt = S_SCAN;
              end
            end
          end
        end else if (!item_r.into_object && item_r.interior_valid &&
                     count_r != '0) begin
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue the next read
        if (rd_idx_r != count_r) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        // Consume the entry read last cycle: skip the first match, keep the rest
        if (pend_r) begin
          if (!found_r && ram_rdata.id == item_r.interior_id) begin
            found_nxt = 1'b1;
          end else begin
            if (is_remove) begin
              ram_req.we = 1'b1;
              wr_idx_nxt = wr_idx_r + 1'b1;
            end
            if (!bp_r || $signed(ram_rdata.prio) >= best_r) begin
              bp_nxt   = 1'b1;
              bid_nxt  = ram_rdata.id;
              best_nxt = ram_rdata.prio;
            end
          end
        end
        // Finish: move to the result and, for a removal, commit it
        if (!pend_r && rd_idx_r == count_r) begin
          state_nxt = S_DONE;
          if (is_remove) begin
            cur_present_nxt = bp_r;
            if (bp_r) begin
              cur_ident_nxt = bid_r;
              cur_prio_nxt  = best_r;
            end
            if (found_r) begin
              count_nxt = count_r - 1'b1;
            end
          end
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Simulated removal: an empty list leaves the current volume
  assign sim_present = (count_r == '0) ? cur_present_r : bp_r;
  assign sim_id      = (count_r == '0) ? cur_ident_r   : bid_r;

  // Build the result word from the updated state
  always_comb begin
    res                 = '0;
    res.current_valid   = cur_present_r;
    res.current_id      = cur_present_r ? cur_ident_r : '0;
    res.scattered_start = scatter_r;
    res.list_count      = LIST_W'(count_r);
    if (item_r.kind == KIND_HIT) begin
      if (item_r.into_object) begin
        // Entering: interior is the stronger of current and material volume
        if (item_r.transmit) begin
          if (!item_r.interior_valid) begin
            res.continue_trace = 1'b1;
          end else if (cur_present_r) begin
            res.continue_trace = (cur_ident_r == item_r.interior_id) ||
                                 (cur_prio_r > $signed(item_r.interior_priority));
          end
        end
        if (item_r.interior_valid) begin
          res.hit_interior_valid = 1'b1;
          res.hit_interior_id =
            (cur_present_r && cur_prio_r > $signed(item_r.interior_priority)) ?
            cur_ident_r : item_r.interior_id;
        end
        if (cur_present_r) begin
          res.hit_exterior_valid = 1'b1;
          res.hit_exterior_id    = cur_ident_r;
        end else if (item_r.exterior_valid) begin
          res.hit_exterior_valid = 1'b1;
          res.hit_exterior_id    = item_r.exterior_id;
        end else if (cfg.default_valid) begin
          res.hit_exterior_valid = 1'b1;
          res.hit_exterior_id    = cfg.default_id;
        end
      end else begin
        // Leaving: exterior is what remains after the simulated removal
        if (item_r.transmit && item_r.null_material && cur_present_r) begin
          res.continue_trace = item_r.interior_valid ?
                               (sim_present && sim_id == cur_ident_r) : 1'b1;
        end
        if (cur_present_r) begin
          res.hit_interior_valid = 1'b1;
          res.hit_interior_id    = cur_ident_r;
        end else if (item_r.interior_valid) begin
          res.hit_interior_valid = 1'b1;
          res.hit_interior_id    = item_r.interior_id;
        end else if (cfg.default_valid) begin
          res.hit_interior_valid = 1'b1;
          res.hit_interior_id    = cfg.default_id;
        end
        if (item_r.interior_valid && sim_present) begin
          res.hit_exterior_valid = 1'b1;
          res.hit_exterior_id    = sim_id;
        end
      end
    end
  end

  // Hold state and scan registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      cur_present_r <= 1'b0;
      cur_ident_r   <= '0;
      cur_prio_r    <= '0;
      scatter_r     <= 1'b0;
      pend_r        <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      cur_present_r <= cur_present_nxt;
      cur_ident_r   <= cur_ident_nxt;
      cur_prio_r    <= cur_prio_nxt;
      scatter_r     <= scatter_nxt;
      pend_r        <= pend_nxt;
    end
    item_r   <= item_nxt;
    rd_idx_r <= rd_idx_nxt;
    wr_idx_r <= wr_idx_nxt;
    found_r  <= found_nxt;
    bp_r     <= bp_nxt;
    bid_r    <= bid_nxt;
    best_r   <= best_nxt;
  end

endmodule
`default_nettype wire

@@ hdl/vps_obuf.sv @@
// Output register that holds one result word until the receiver takes it.
`default_nettype none
module vps_obuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  output logic             res_ready,
  input  vps_pkg::result_t res,
  output logic             out_valid,
  input  logic             out_stall,
  output vps_pkg::result_t out_res
);
  import vps_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r, data_nxt;

  assign res_ready = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = data_r;

  // Load a new word when empty or when the held word leaves
  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r && out_stall;
    if (res_valid && res_ready) begin
      data_nxt  = res;
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

endmodule
`default_nettype wire

@@ hdl/volume_priority_stack.sv @@
// Top level of the volume priority stack: ports, configuration, entry memory.
// The block keeps a list of up to MAX_VOLUMES entered volumes in a single
// entry memory and tracks the current (highest priority, latest on ties)
// volume. One word is taken at a time. A word that needs no list scan goes
// from the execute state straight to the result state; a removal or an exiting
// hit query with an interior volume and a nonempty list scans the list through
// the memory's one read port before the result. The next word is accepted the
// cycle after the result moves into the output register, so a waiting result
// does not hold off the next word. No clearing pass is needed after reset.
// Configuration writes are always ready.
`default_nettype none
module volume_priority_stack (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_kind,
  input  logic                                  in_volume_scatter,
  input  logic                                  in_transmit,
  input  logic                                  in_into_object,
  input  logic                                  in_null_material,
  input  logic                                  in_interior_valid,
  input  logic [vps_pkg::ID_W-1:0]              in_interior_id,
  input  logic signed [vps_pkg::PRIO_W-1:0]     in_interior_priority,
  input  logic                                  in_exterior_valid,
  input  logic [vps_pkg::ID_W-1:0]              in_exterior_id,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_continue_trace,
  output logic                                  out_hit_interior_valid,
  output logic [vps_pkg::ID_W-1:0]              out_hit_interior_id,
  output logic                                  out_hit_exterior_valid,
  output logic [vps_pkg::ID_W-1:0]              out_hit_exterior_id,
  output logic                                  out_current_valid,
  output logic [vps_pkg::ID_W-1:0]              out_current_id,
  output logic                                  out_scattered_start,
  output logic [vps_pkg::LIST_W-1:0]            out_list_count,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [vps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [vps_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import vps_pkg::*;

  cfg_t     cfg_r;
  item_t    item;
  ram_req_t ram_req;
  entry_t   ram_rdata;
  logic     res_valid;
  logic     res_ready;
  result_t  res;
  result_t  out_res;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEFAULT_VALID: cfg_r.default_valid <= cfg_data[0];
        CFG_DEFAULT_ID:    cfg_r.default_id    <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // Gather the input word
  assign item.kind              = in_kind;
  assign item.volume_scatter    = in_volume_scatter;
  assign item.transmit          = in_transmit;
  assign item.into_object       = in_into_object;
  assign item.null_material     = in_null_material;
  assign item.interior_valid    = in_interior_valid;
  assign item.interior_id       = in_interior_id;
  assign item.interior_priority = in_interior_priority;
  assign item.exterior_valid    = in_exterior_valid;
  assign item.exterior_id       = in_exterior_id;

  vps_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .item      (item),
    .cfg       (cfg_r),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  vps_ram #(
    .DEPTH (MAX_VOLUMES),
    .WIDTH ($bits(entry_t))
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  vps_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // Spread the result word over the output ports
  assign out_continue_trace     = out_res.continue_trace;
  assign out_hit_interior_valid = out_res.hit_interior_valid;
  assign out_hit_interior_id    = out_res.hit_interior_id;
  assign out_hit_exterior_valid = out_res.hit_exterior_valid;
  assign out_hit_exterior_id    = out_res.hit_exterior_id;
  assign out_current_valid      = out_res.current_valid;
  assign out_current_id         = out_res.current_id;
  assign out_scattered_start    = out_res.scattered_start;
  assign out_list_count         = out_res.list_count;

endmodule
`default_nettype wire

@@ hdl/vps_checker.sv @@
// Port-level checks of the volume priority stack and their bind.
`default_nettype none
module vps_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_hit_interior_valid,
  input logic [vps_pkg::ID_W-1:0]    out_hit_interior_id,
  input logic                        out_current_valid,
  input logic [vps_pkg::ID_W-1:0]    out_current_id,
  input logic [vps_pkg::LIST_W-1:0]  out_list_count
);
  import vps_pkg::*;

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // A stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_current_id) &&
                               $stable(out_list_count))
    else $error("stalled result word changed");

  // An accepted word makes the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted back to back");

  // A nonempty list always has a current volume
  a_list_has_current: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_list_count != '0 |-> out_current_valid)
    else $error("nonempty list without current volume");

  // Absent volumes report id zero
  a_absent_ids_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_current_valid || out_current_id == '0) &&
                  (out_hit_interior_valid || out_hit_interior_id == '0))
    else $error("absent volume with nonzero id");

endmodule

bind volume_priority_stack vps_checker u_vps_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_valid),
  .in_stall               (in_stall),
  .out_valid              (out_valid),
  .out_stall              (out_stall),
  .out_hit_interior_valid (out_hit_interior_valid),
  .out_hit_interior_id    (out_hit_interior_id),
  .out_current_valid      (out_current_valid),
  .out_current_id         (out_current_id),
  .out_list_count         (out_list_count)
);
`default_nettype wire

@@ sim/volume_priority_stack_tb.sv @@
// Self-checking testbench for the volume priority stack, with its own list predictor.
`timescale 1ns / 100ps

module volume_priority_stack_tb;
  import vps_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = MAX_VOLUMES + 8;
  localparam int PHASES      = 5;
  localparam int PHASE_WORDS = 230;

  typedef struct packed {
    logic            on;
    logic [ID_W-1:0] id;
  } vol_ref_t;

  typedef struct packed {
    bit              world_set;
    logic            world_dv;
    logic [ID_W-1:0] world_did;
    item_t           w;
    bit              typed;
    result_t         want;
  } dir_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_kind;
  logic                     in_volume_scatter;
  logic                     in_transmit;
  logic                     in_into_object;
  logic                     in_null_material;
  logic                     in_interior_valid;
  logic [ID_W-1:0]          in_interior_id;
  logic signed [PRIO_W-1:0] in_interior_priority;
  logic                     in_exterior_valid;
  logic [ID_W-1:0]          in_exterior_id;
  logic                     out_valid;
  logic                     out_stall;
  logic                     out_continue_trace;
  logic                     out_hit_interior_valid;
  logic [ID_W-1:0]          out_hit_interior_id;
  logic                     out_hit_exterior_valid;
  logic [ID_W-1:0]          out_hit_exterior_id;
  logic                     out_current_valid;
  logic [ID_W-1:0]          out_current_id;
  logic                     out_scattered_start;
  logic [LIST_W-1:0]        out_list_count;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  volume_priority_stack dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_kind                (in_kind),
    .in_volume_scatter      (in_volume_scatter),
    .in_transmit            (in_transmit),
    .in_into_object         (in_into_object),
    .in_null_material       (in_null_material),
    .in_interior_valid      (in_interior_valid),
    .in_interior_id         (in_interior_id),
    .in_interior_priority   (in_interior_priority),
    .in_exterior_valid      (in_exterior_valid),
    .in_exterior_id         (in_exterior_id),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_continue_trace     (out_continue_trace),
    .out_hit_interior_valid (out_hit_interior_valid),
    .out_hit_interior_id    (out_hit_interior_id),
    .out_hit_exterior_valid (out_hit_exterior_valid),
    .out_hit_exterior_id    (out_hit_exterior_id),
    .out_current_valid      (out_current_valid),
    .out_current_id         (out_current_id),
    .out_scattered_start    (out_scattered_start),
    .out_list_count         (out_list_count),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  // Predictor state: entered volumes, current volume, scatter flag, world volume
  entry_t                   vol_list [MAX_VOLUMES];
  int unsigned              vol_count;
  logic                     top_on;
  logic [ID_W-1:0]          top_id;
  logic signed [PRIO_W-1:0] top_prio;
  logic                     scat_on;
  logic                     world_on;
  logic [ID_W-1:0]          world_id;

  result_t  expected_q [$];
  dir_row_t directed_rows [$];
  result_t  typed_want;

  int  faults;
  int  words_sent;
  int  queries_sent;
  int  results_checked;
  int  full_drops;
  int  unlisted_exits;
  int  peak_fill;
  int  cycle_cnt;
  int  tx_gap_pct;
  int  rx_stall_pct;
  bit  quiet;
  bit  hold_req;
  int  rx_burst_left;
  bit  rx_level;

  // Enter a volume; a full list drops the word
  function automatic void enter_volume(logic [ID_W-1:0] id, logic signed [PRIO_W-1:0] p);
    if (vol_count >= MAX_VOLUMES) begin
      full_drops++;
      return;
    end
    if (!top_on || p >= top_prio) begin
      top_on   = 1'b1;
      top_id   = id;
      top_prio = p;
    end
    vol_list[vol_count].id   = id;
    vol_list[vol_count].prio = p;
    vol_count++;
    if (vol_count > peak_fill) peak_fill = vol_count;
  endfunction

  // Drop the first match, compact, and rescan for the current volume
  function automatic void leave_volume(logic [ID_W-1:0] id);
    int unsigned              kept;
    bit                       found;
    logic signed [PRIO_W-1:0] ep;
    entry_t                   e;
    kept  = 0;
    found = 1'b0;
    if (vol_count == 0) return;
    top_on = 1'b0;
    for (int i = 0; i < vol_count; i++) begin
      e  = vol_list[i];
      ep = e.prio;
      if (!found && e.id == id) begin
        found = 1'b1;
        continue;
      end
      vol_list[kept] = e;
      kept++;
      if (!top_on || ep >= top_prio) begin
        top_on   = 1'b1;
        top_id   = e.id;
        top_prio = ep;
      end
    end
    if (found) vol_count--;
    else unlisted_exits++;
  endfunction

  // Current volume as it would be with one volume taken out; state untouched
  function automatic vol_ref_t peek_without(logic [ID_W-1:0] id);
    vol_ref_t                 r;
    logic signed [PRIO_W-1:0] best;
    logic signed [PRIO_W-1:0] ep;
    bit                       found;
    r     = '0;
    best  = '0;
    found = 1'b0;
    if (vol_count == 0) begin
      r.on = top_on;
      r.id = top_on ? top_id : '0;
      return r;
    end
    for (int i = 0; i < vol_count; i++) begin
      ep = vol_list[i].prio;
      if (!found && vol_list[i].id == id) begin
        found = 1'b1;
        continue;
      end
      if (!r.on || ep >= best) begin
        r.on = 1'b1;
        r.id = vol_list[i].id;
        best = ep;
      end
    end
    return r;
  endfunction

  // Advance the predictor by one accepted word and return its result
  function automatic result_t step_volumes(item_t w);
    result_t                  r;
    vol_ref_t                 hin;
    vol_ref_t                 hout;
    vol_ref_t                 s;
    logic signed [PRIO_W-1:0] p;
    r    = '0;
    hin  = '0;
    hout = '0;
    p    = w.interior_priority;
    if (w.kind == KIND_SCATTER) begin
      if (w.volume_scatter) begin
        scat_on = 1'b1;
      end else begin
        scat_on = 1'b0;
        if (w.transmit && w.interior_valid) begin
          if (w.into_object) enter_volume(w.interior_id, p);
          else leave_volume(w.interior_id);
        end
      end
    end else begin
      queries_sent++;
      // pass-through decision
      if (w.transmit) begin
        if (w.into_object) begin
          if (!w.interior_valid) r.continue_trace = 1'b1;
          else if (top_on) r.continue_trace = (top_id == w.interior_id) || (top_prio > p);
        end else if (w.null_material && top_on) begin
          if (w.interior_valid) begin
            s = peek_without(w.interior_id);
          end else begin
            s.on = 1'b1;
            s.id = top_id;
          end
          r.continue_trace = s.on && (s.id == top_id);
        end
      end
      // volumes on either side of the hit point
      if (w.into_object) begin
        if (w.interior_valid) begin
          hin.on = 1'b1;
          hin.id = (top_on && top_prio > p) ? top_id : w.interior_id;
        end
        if (top_on) begin
          hout.on = 1'b1;
          hout.id = top_id;
        end else if (w.exterior_valid) begin
          hout.on = 1'b1;
          hout.id = w.exterior_id;
        end
        if (!hout.on && world_on) begin
          hout.on = 1'b1;
          hout.id = world_id;
        end
      end else begin
        if (top_on) begin
          hin.on = 1'b1;
          hin.id = top_id;
        end else if (w.interior_valid) begin
          hin.on = 1'b1;
          hin.id = w.interior_id;
        end
        if (!hin.on && world_on) begin
          hin.on = 1'b1;
          hin.id = world_id;
        end
        if (w.interior_valid) hout = peek_without(w.interior_id);
      end
    end
    r.hit_interior_valid = hin.on;
    r.hit_interior_id    = hin.id;
    r.hit_exterior_valid = hout.on;
    r.hit_exterior_id    = hout.id;
    r.current_valid      = top_on;
    r.current_id         = top_on ? top_id : '0;
    r.scattered_start    = scat_on;
    r.list_count         = LIST_W'(vol_count);
    return r;
  endfunction

  function automatic item_t mk_word(logic kind, logic vs, logic tx, logic into, logic nm,
                                    logic iv, logic [ID_W-1:0] iid,
                                    logic signed [PRIO_W-1:0] ipr,
                                    logic ev, logic [ID_W-1:0] eid);
    item_t w;
    w.kind              = kind;
    w.volume_scatter    = vs;
    w.transmit          = tx;
    w.into_object       = into;
    w.null_material     = nm;
    w.interior_valid    = iv;
    w.interior_id       = iid;
    w.interior_priority = ipr;
    w.exterior_valid    = ev;
    w.exterior_id       = eid;
    return w;
  endfunction

  function automatic void add_row(item_t w, bit typed, result_t want);
    dir_row_t row;
    row       = '0;
    row.w     = w;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_world(logic dv, logic [ID_W-1:0] did);
    dir_row_t row;
    row           = '0;
    row.world_set = 1'b1;
    row.world_dv  = dv;
    row.world_did = did;
    directed_rows.push_back(row);
  endfunction

  // Favor ids already in the list so exits and queries find them
  function automatic logic [ID_W-1:0] pick_id();
    int sel;
    sel = $urandom_range(0, 99);
    if (vol_count != 0 && sel < 65) return vol_list[$urandom_range(0, vol_count - 1)].id;
    if (sel < 85) return ID_W'($urandom_range(0, 15));
    return ID_W'($urandom);
  endfunction

  // Extremes and ties come up often
  function automatic logic signed [PRIO_W-1:0] pick_prio();
    case ($urandom_range(0, 6))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return top_prio;
      4: return (vol_count != 0) ? vol_list[$urandom_range(0, vol_count - 1)].prio : 16'sh0;
      5: return PRIO_W'($urandom_range(0, 6) - 3);
      default: return PRIO_W'($urandom);
    endcase
  endfunction

  // Mostly well-formed enter/exit traffic, some pure noise
  function automatic item_t make_word();
    item_t       w;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    w   = raw[$bits(item_t)-1:0];
    if ($urandom_range(0, 99) < 10) return w;
    w.kind              = ($urandom_range(0, 99) < 35) ? KIND_HIT : KIND_SCATTER;
    w.interior_id       = pick_id();
    w.interior_priority = pick_prio();
    if (w.kind == KIND_SCATTER) begin
      w.volume_scatter = ($urandom_range(0, 99) < 12);
      w.transmit       = ($urandom_range(0, 99) < 90);
      if (vol_count == 0) w.into_object = ($urandom_range(0, 99) < 85);
      else if (vol_count >= MAX_VOLUMES) w.into_object = ($urandom_range(0, 99) < 25);
      else w.into_object = ($urandom_range(0, 99) < 55);
      w.interior_valid = ($urandom_range(0, 99) < 92);
    end else begin
      w.transmit       = ($urandom_range(0, 99) < 80);
      w.into_object    = ($urandom_range(0, 99) < 50);
      w.null_material  = ($urandom_range(0, 99) < 60);
      w.interior_valid = ($urandom_range(0, 99) < 85);
    end
    return w;
  endfunction

  // Offer a word, hold it until taken, then record its expected result
  task automatic send_word(item_t w, bit typed, result_t want);
    result_t pred;
    in_valid             <= 1'b1;
    in_kind              <= w.kind;
    in_volume_scatter    <= w.volume_scatter;
    in_transmit          <= w.transmit;
    in_into_object       <= w.into_object;
    in_null_material     <= w.null_material;
    in_interior_valid    <= w.interior_valid;
    in_interior_id       <= w.interior_id;
    in_interior_priority <= w.interior_priority;
    in_exterior_valid    <= w.exterior_valid;
    in_exterior_id       <= w.exterior_id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = step_volumes(w);
    expected_q.push_back(typed ? want : pred);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Stop sending and wait until every expected result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // Write both world-volume registers back to back
  task automatic set_world(logic dv, logic [ID_W-1:0] did);
    logic [CFG_IDX_W-1:0]  idx [2];
    logic [CFG_DATA_W-1:0] val [2];
    idx[0] = CFG_DEFAULT_VALID;
    val[0] = CFG_DATA_W'(dv);
    idx[1] = CFG_DEFAULT_ID;
    val[1] = did;
    for (int k = 0; k < 2; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (idx[k] == CFG_DEFAULT_VALID) world_on = val[k][0];
      else world_id = val[k];
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic note_fault(string msg);
    faults++;
    if (faults <= 10) $display("MISMATCH: %s", msg);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want)
      note_fault($sformatf("result %0d field %s expected %h got %h",
                           results_checked, name, want, got));
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("volume_priority_stack verification failed");
      $finish;
    end
  end

  // Result receiver: random stall bursts, or one long hold on request
  initial begin
    out_stall     = 1'b0;
    rx_burst_left = 0;
    rx_level      = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_req      = 1'b0;
        rx_burst_left = 0;
      end else begin
        if (rx_burst_left == 0) begin
          rx_level      = ($urandom_range(0, 99) < rx_stall_pct);
          rx_burst_left = $urandom_range(1, 19);
        end
        rx_burst_left--;
        out_stall <= rx_level && !quiet;
      end
    end
  end

  // Compare each taken result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_q.size() == 0) begin
        note_fault($sformatf("result with nothing expected, current_id %h count %0d",
                             out_current_id, out_list_count));
      end else begin
        typed_want = expected_q.pop_front();
        check_field("continue_trace", 16'(typed_want.continue_trace),
                    16'(out_continue_trace));
        check_field("hit_interior_valid", 16'(typed_want.hit_interior_valid),
                    16'(out_hit_interior_valid));
        check_field("hit_interior_id", 16'(typed_want.hit_interior_id),
                    16'(out_hit_interior_id));
        check_field("hit_exterior_valid", 16'(typed_want.hit_exterior_valid),
                    16'(out_hit_exterior_valid));
        check_field("hit_exterior_id", 16'(typed_want.hit_exterior_id),
                    16'(out_hit_exterior_id));
        check_field("current_valid", 16'(typed_want.current_valid),
                    16'(out_current_valid));
        check_field("current_id", 16'(typed_want.current_id), 16'(out_current_id));
        check_field("scattered_start", 16'(typed_want.scattered_start),
                    16'(out_scattered_start));
        check_field("list_count", 16'(typed_want.list_count), 16'(out_list_count));
      end
      results_checked++;
    end
  end

  // Stimulus
  initial begin
    result_t r;
    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_kind              = KIND_SCATTER;
    in_volume_scatter    = 1'b0;
    in_transmit          = 1'b0;
    in_into_object       = 1'b0;
    in_null_material     = 1'b0;
    in_interior_valid    = 1'b0;
    in_interior_id       = '0;
    in_interior_priority = '0;
    in_exterior_valid    = 1'b0;
    in_exterior_id       = '0;
    cfg_valid            = 1'b0;
    cfg_index            = CFG_DEFAULT_VALID;
    cfg_data             = '0;
    faults = 0; words_sent = 0; queries_sent = 0; results_checked = 0;
    full_drops = 0; unlisted_exits = 0; peak_fill = 0; cycle_cnt = 0;
    tx_gap_pct = 20; rx_stall_pct = 25; quiet = 1'b0; hold_req = 1'b0;
    vol_count = 0; top_on = 1'b0; top_id = '0; top_prio = '0; scat_on = 1'b0;
    world_on = 1'b0; world_id = '0;
    for (int i = 0; i < MAX_VOLUMES; i++) vol_list[i] = '0;

    // Directed table; typed results hold for the state right after reset
    r = '0;
    r.continue_trace = 1'b1;
    // enter query, no volume anywhere, no world volume
    add_row(mk_word(KIND_HIT, 0, 1, 1, 0, 0, 8'h00, 16'sh0000, 0, 8'h00), 1'b1, r);
    r = '0;
    // exit null-material query on empty state
    add_row(mk_word(KIND_HIT, 0, 1, 0, 1, 0, 8'hFF, 16'sh8000, 1, 8'hFF), 1'b1, r);
    r = '0;
    r.scattered_start = 1'b1;
    // volume scattering only sets the flag
    add_row(mk_word(KIND_SCATTER, 1, 1, 1, 0, 1, 8'h10, 16'sh7FFF, 0, 8'h00), 1'b1, r);
    r = '0;
    // exit from an empty list: ignored, flag cleared
    add_row(mk_word(KIND_SCATTER, 0, 1, 0, 0, 1, 8'h05, 16'sh0000, 0, 8'h00), 1'b1, r);
    add_world(1'b1, 8'hFF);
    // empty list with the world volume set: exit and enter queries
    add_row(mk_word(KIND_HIT, 0, 1, 0, 1, 1, 8'h09, 16'sh0000, 0, 8'h00), 1'b0, r);
    add_row(mk_word(KIND_HIT, 0, 1, 1, 0, 0, 8'h00, 16'sh0000, 0, 8'h00), 1'b0, r);
    add_row(mk_word(KIND_HIT, 0, 0, 1, 0, 1, 8'h01, 16'sh0000, 1, 8'h3C), 1'b0, r);
    // fill the list, priority extremes and a tie, then push once more when full
    add_row(mk_word(KIND_SCATTER, 0, 1, 1, 0, 1, 8'h00, 16'sh8000, 0, 8'h00), 1'b0, r);
    add_row(mk_word(KIND_SCATTER, 0, 1, 1, 0, 1, 8'hFF, 16'sh7FFF, 0, 8'h00), 1'b0, r);
    add_row(mk_word(KIND_SCATTER, 0, 1, 1, 0, 1, 8'h11, 16'sh7FFF, 0, 8'h00), 1'b0, r);
    add_row(mk_word(KIND_SCATTER, 0, 1, 1, 0, 1, 8'h22, 16'sh0000, 0, 8'h00), 1'b0, r);
    add_row(mk_word(KIND_SCATTER, 0, 1, 1, 0, 1, 8'h33, 16'shFFFF, 0, 8'h00), 1'b0, r);
    add_row(mk_word(KIND_SCATTER, 0, 1, 1, 0, 1, 8'h44, 16'sh1234, 0, 8'h00), 1'b0, r);
    add_row(mk_word(KIND_SCATTER, 0, 1, 1, 0, 1, 8'h55, 16'sh8000, 0, 8'h00), 1'b0, r);
    add_row(mk_word(KIND_SCATTER, 0, 1, 1, 0, 1, 8'h66, 16'sh0064, 0, 8'h00), 1'b0, r);
    add_row(mk_word(KIND_SCATTER, 0, 1, 1, 0, 1, 8'h77, 16'sh7FFF, 0, 8'h00), 1'b0, r);
    // no transmission, then no interior volume: both ignored
    add_row(mk_word(KIND_SCATTER, 0, 0, 1, 1, 1, 8'h88, 16'sh7FFF, 1, 8'hFF), 1'b0, r);
    add_row(mk_word(KIND_SCATTER, 0, 1, 0, 1, 0, 8'h11, 16'sh7FFF, 1, 8'hFF), 1'b0, r);
    // enter queries: lower priority, and same id as current
    add_row(mk_word(KIND_HIT, 1, 1, 1, 0, 1, 8'hAA, 16'sh8000, 1, 8'h01), 1'b0, r);
    add_row(mk_word(KIND_HIT, 0, 1, 1, 1, 1, 8'h11, 16'sh8000, 0, 8'h00), 1'b0, r);
    // exit null-material queries with and without interior
    add_row(mk_word(KIND_HIT, 0, 1, 0, 1, 1, 8'h11, 16'sh0000, 1, 8'hFF), 1'b0, r);
    add_row(mk_word(KIND_HIT, 0, 1, 0, 1, 0, 8'h00, 16'sh0000, 0, 8'h00), 1'b0, r);
    // exit of an unlisted volume, then of the current one
    add_row(mk_word(KIND_SCATTER, 0, 1, 0, 0, 1, 8'h99, 16'sh0000, 0, 8'h00), 1'b0, r);
    add_row(mk_word(KIND_SCATTER, 0, 1, 0, 0, 1, 8'h11, 16'sh0000, 0, 8'h00), 1'b0, r);

    // Reset
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].world_set) begin
        drain_results();
        set_world(directed_rows[i].world_dv, directed_rows[i].world_did);
      end else begin
        if ($urandom_range(0, 99) < tx_gap_pct) pause_sender($urandom_range(1, 19));
        send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases, each under its own world-volume setting
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin set_world(1'b0, 8'h00); tx_gap_pct = 30; rx_stall_pct = 30; end
        1: begin set_world(1'b1, 8'hFF); tx_gap_pct = 10; rx_stall_pct = 50; end
        2: begin set_world(1'b1, 8'h00); tx_gap_pct = 0;  rx_stall_pct = 0;  end
        3: begin set_world(1'b0, 8'hFF); tx_gap_pct = 50; rx_stall_pct = 20; end
        default: begin
          set_world(1'b1, ID_W'($urandom));
          tx_gap_pct = 0;
          rx_stall_pct = 0;
          quiet = 1'b1;
        end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // long receiver hold while words keep coming; later a full sender pause
        if (ph == 1 && n == 40) hold_req = 1'b1;
        if (ph == 2 && n == PHASE_WORDS / 2) drain_results();
        if (!quiet && tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct)
          pause_sender($urandom_range(1, 19));
        send_word(make_word(), 1'b0, '0);
      end
    end
    drain_results();

    $display("Sent %0d words (%0d hit queries) over %0d world settings, %0d results checked.",
             words_sent, queries_sent, PHASES + 1, results_checked);
    $display("List peaked at %0d of %0d; %0d pushes dropped when full, %0d unlisted exits.",
             peak_fill, MAX_VOLUMES, full_drops, unlisted_exits);
    if (faults == 0) begin
      $display("volume_priority_stack verification clean");
    end else begin
      $display("%0d mismatches in total", faults);
      $display("volume_priority_stack verification failed");
    end
    $finish;
  end

endmodule
